// File: rtl/psp_pkg.sv
package psp_pkg;

  typedef enum logic [2:0] {
    OP_KEY     = 3'd0,
    OP_REL_ALL = 3'd1,
    OP_WR_DESC = 3'd2,
    OP_WR_BYTE = 3'd3,
    OP_RENDER  = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DESC,
    ST_BYTE,
    ST_MIX,
    ST_OUT
  } state_e;

  localparam int unsigned BlockBytes = 32'h800;
  localparam int unsigned StepMul    = 277;
  localparam int unsigned StepDiv    = 240;

  // Phase step pitch*256*277 / (220*240) in lowest terms is pitch*1108/825. The
  // divide by 825 is a multiply by ceil(2^37/825), exact for any 27-bit product.
  localparam int unsigned     StepNumMul = 1108;
  localparam longint unsigned StepRecip  = 64'd166592671;
  localparam int unsigned     StepShift  = 37;

endpackage

// File: rtl/polyphonic_sample_player_core.sv
// Eight-voice sample player. An item is one of five ops: key event, release all,
// descriptor write, sample byte write, render. Each item gives exactly one result.
// Flow: key events, release all, store writes and unused ops offer their result
// in the cycle after the transfer, and the next transfer can follow in the cycle
// after the result transfer, so items are taken one at a time. A render visits
// the voices one at a time: a held voice goes through descriptor read, sample
// read, multiply, and accumulate and write back; a voice that is not held is
// skipped, and a last voice that is not held ends the pass with a closing step.
// A further state then loads the result register and offers the render result.
// The input is taken again once the result register is free. Voice state lives in
// per-voice registers; descriptors and sample bytes live in synchronous memories
// that are not cleared after reset. The phase step is fixed for a reference pitch
// of 220.
module polyphonic_sample_player_core #(
  parameter int unsigned VOICES          = 8,
  parameter int unsigned SAMPLE_SLOTS    = 256,
  parameter int unsigned SAMPLE_BYTES    = 1048576
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         op_i,
  input  logic               key_down_i,
  input  logic [15:0]        pitch_i,
  input  logic [7:0]         slot_i,
  input  logic [7:0]         gain_i,
  input  logic [7:0]         table_index_i,
  input  logic [8:0]         region_start_i,
  input  logic [7:0]         length_code_i,
  input  logic [19:0]        mem_address_i,
  input  logic signed [7:0]  mem_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] audio_sample_o,
  output logic [2:0]         voice_index_o,
  output logic               voice_valid_o,
  output logic [3:0]         held_count_o
);
  import psp_pkg::*;

  localparam int unsigned VW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int unsigned CW = $clog2(VOICES + 1);
  localparam int unsigned AW = $clog2(SAMPLE_BYTES);
  localparam int unsigned SW = (SAMPLE_SLOTS > 1) ? $clog2(SAMPLE_SLOTS) : 1;

  // voice registers
  logic [VOICES-1:0] held_q, ended_q;
  logic [15:0] vpitch_q [VOICES];
  logic [7:0]  vslot_q  [VOICES];
  logic [7:0]  vgain_q  [VOICES];
  logic [31:0] vpos_q   [VOICES];

  // stores
  logic [16:0] desc_mem [SAMPLE_SLOTS];
  logic [7:0]  smp_mem  [SAMPLE_BYTES];
  logic [16:0] desc_rd_q;
  logic [7:0]  smp_rd_q;
  logic        desc_ok_q;

  state_e state_q, state_d;
  logic [VW-1:0] vi_q;
  logic [15:0] acc_q;
  logic        shift5_q;
  logic [2:0]  sub_q;

  logic        ov_q;
  logic [15:0] aud_q;
  logic [2:0]  vidx_q;
  logic        vval_q;

  logic [CW-1:0] held_cnt;
  always_comb begin
    held_cnt = '0;
    for (int v = 0; v < VOICES; v++) held_cnt = held_cnt + CW'(held_q[v]);
  end

  assign in_ready_o = (state_q == ST_IDLE) && !ov_q;
  wire take = in_valid_i && in_ready_o;

  // key matching and free-voice search over the voice registers
  logic [VW-1:0] match_v, free_v;
  logic match_f, free_f;
  always_comb begin
    match_f = 1'b0; match_v = '0; free_f = 1'b0; free_v = '0;
    for (int v = VOICES - 1; v >= 0; v--) begin
      if (held_q[v] && vpitch_q[v] == pitch_i && vslot_q[v] == slot_i) begin
        match_f = 1'b1; match_v = VW'(v);
      end
      if (!held_q[v]) begin
        free_f = 1'b1; free_v = VW'(v);
      end
    end
  end

  // per-voice decode
  wire [8:0]  d_start = desc_rd_q[16:8];
  wire [7:0]  d_code  = desc_ok_q ? desc_rd_q[7:0] : 8'd0;
  wire [8:0]  d_startm = desc_ok_q ? d_start : 9'd0;
  wire [23:0] idx = vpos_q[vi_q][31:8];
  wire [2:0]  lexp = d_code[6:4];
  wire        past = (idx >> (11 + lexp)) != 24'd0;
  wire [AW-1:0] rd_addr = AW'({d_startm, 11'd0} + {8'd0, idx});

  // phase step: pitch*1108 registered, then a reciprocal multiply for the /825,
  // registered again; both are ready by the accumulate cycle
  logic [26:0] stepnum_q;
  logic [16:0] step_q;
  wire  [54:0] step_prod = {28'd0, stepnum_q} * 55'(StepRecip);
  logic [15:0] prod_q;

  wire [SW-1:0] slot_a = SW'(vslot_q[vi_q]);
  wire slot_ok = 32'(vslot_q[vi_q]) < SAMPLE_SLOTS;

  always_ff @(posedge clk_i) begin
    if (take && op_i == OP_WR_DESC && 32'(table_index_i) < SAMPLE_SLOTS)
      desc_mem[SW'(table_index_i)] <= {region_start_i, length_code_i};
    if (take && op_i == OP_WR_BYTE)
      smp_mem[AW'(mem_address_i)] <= mem_byte_i;
    desc_rd_q <= desc_mem[slot_a];
    desc_ok_q <= slot_ok;
    smp_rd_q  <= smp_mem[rd_addr];
    stepnum_q <= {11'd0, vpitch_q[vi_q]} * 27'(StepNumMul);
    step_q    <= step_prod[StepShift +: 17];
    prod_q    <= 16'($signed(smp_rd_q) * $signed({1'b0, vgain_q[vi_q]}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  wire last_v = (vi_q == VW'(VOICES - 1));
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (take && op_i == OP_RENDER) state_d = ST_MIX;
      ST_MIX:  if (sub_q == 3'd3 && last_v) state_d = ST_OUT;
      ST_OUT:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0; ended_q <= '1; ov_q <= 1'b0;
      vi_q <= '0; sub_q <= '0; acc_q <= '0; shift5_q <= 1'b0;
      aud_q <= '0; vidx_q <= '0; vval_q <= 1'b0;
      for (int v = 0; v < VOICES; v++) begin
        vpitch_q[v] <= '0; vslot_q[v] <= '0; vgain_q[v] <= '0; vpos_q[v] <= '0;
      end
    end else begin
      if (out_valid_o && out_ready_i) ov_q <= 1'b0;
      if (take) begin
        aud_q <= '0;
        unique case (op_i)
          OP_KEY: begin
            if (key_down_i && !match_f && free_f) begin
              held_q[free_v] <= 1'b1; ended_q[free_v] <= 1'b0;
              vpos_q[free_v] <= '0; vpitch_q[free_v] <= pitch_i;
              vslot_q[free_v] <= slot_i; vgain_q[free_v] <= gain_i;
              vidx_q <= 3'(free_v); vval_q <= 1'b1;
            end else if (!key_down_i && match_f) begin
              held_q[match_v] <= 1'b0;
              vidx_q <= 3'(match_v); vval_q <= 1'b1;
            end else begin
              vidx_q <= '0; vval_q <= 1'b0;
            end
            ov_q <= 1'b1;
          end
          OP_REL_ALL: begin
            held_q <= '0; ended_q <= '1;
            for (int v = 0; v < VOICES; v++) begin
              vpitch_q[v] <= '0; vslot_q[v] <= 8'hFF;
            end
            ov_q <= 1'b1;
          end
          OP_RENDER: begin
            vi_q <= '0; sub_q <= '0; acc_q <= '0;
            shift5_q <= (held_cnt == CW'(1));
          end
          default: ov_q <= 1'b1;
        endcase
        if (op_i != OP_KEY) begin
          vidx_q <= '0; vval_q <= 1'b0;
        end
      end
      if (state_q == ST_MIX) begin
        // sub 0: descriptor read; 1: sample read; 2: multiply; 3: accumulate, write back
        if (sub_q == 3'd3) begin
          sub_q <= '0;
          if (held_q[vi_q]) begin
            if (past) begin
              if (d_code[7]) vpos_q[vi_q] <= '0;
              else ended_q[vi_q] <= 1'b1;
            end else begin
              acc_q <= acc_q + (shift5_q ? {prod_q[10:0], 5'd0} : {prod_q[11:0], 4'd0});
              vpos_q[vi_q] <= vpos_q[vi_q] + {15'd0, step_q};
            end
          end
          if (!last_v) vi_q <= vi_q + VW'(1);
        end else if (!held_q[vi_q]) begin
          // skip a voice that is not held; the last one closes the pass
          if (last_v) begin
            sub_q <= 3'd3;
          end else begin
            sub_q <= '0;
            vi_q <= vi_q + VW'(1);
          end
        end else begin
          sub_q <= sub_q + 3'd1;
        end
      end
      if (state_q == ST_OUT) begin
        aud_q <= acc_q; ov_q <= 1'b1;
      end
    end
  end

  assign out_valid_o    = ov_q;
  assign audio_sample_o = aud_q;
  assign voice_index_o  = vidx_q;
  assign voice_valid_o  = vval_q;
  assign held_count_o   = 4'(held_cnt);

  ap_no_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_IDLE |-> !in_ready_o) else $error("transfer while busy");
  ap_out_after_mix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_OUT |=> out_valid_o) else $error("render result lost");
  ap_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_cnt <= CW'(VOICES)) else $error("held count overflow");
endmodule

// File: tb/sv/tb_polyphonic_sample_player_core.sv
module tb_polyphonic_sample_player_core;
  timeunit 1ns;
  timeprecision 1ps;

  import psp_pkg::*;

  localparam int unsigned NumVoices  = 8;
  localparam int unsigned MemBytes   = 1048576;
  localparam int unsigned PitchRef   = 220;
  localparam int unsigned RandItems  = 1450;
  localparam int unsigned IdleLimit  = 20000;
  localparam logic [2:0]  OpSpareLo  = 3'd5;
  localparam logic [2:0]  OpSpareHi  = 3'd7;
  localparam logic [7:0]  LoopFlag   = 8'h80;
  localparam logic [7:0]  ExpMask    = 8'h70;
  localparam logic [7:0]  ReleasedSlot = 8'hFF;

  typedef struct {
    logic [2:0]  op;
    logic        key_down;
    logic [15:0] pitch;
    logic [7:0]  slot;
    logic [7:0]  gain;
    logic [7:0]  table_index;
    logic [8:0]  region_start;
    logic [7:0]  length_code;
    logic [19:0] mem_address;
    logic [7:0]  mem_byte;
    bit          drain_first;
  } player_cmd_t;

  typedef struct {
    logic [15:0] audio;
    logic [2:0]  voice;
    logic        voice_valid;
    logic [3:0]  held;
  } player_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  op = '0;
  logic        key_down = 1'b0;
  logic [15:0] pitch = '0;
  logic [7:0]  slot = '0;
  logic [7:0]  gain = '0;
  logic [7:0]  table_index = '0;
  logic [8:0]  region_start = '0;
  logic [7:0]  length_code = '0;
  logic [19:0] mem_address = '0;
  logic signed [7:0] mem_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic signed [15:0] audio_sample;
  logic [2:0]  voice_index;
  logic        voice_valid;
  logic [3:0]  held_count;

  polyphonic_sample_player_core dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .op_i(op), .key_down_i(key_down), .pitch_i(pitch), .slot_i(slot), .gain_i(gain),
    .table_index_i(table_index), .region_start_i(region_start),
    .length_code_i(length_code), .mem_address_i(mem_address), .mem_byte_i(mem_byte),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .audio_sample_o(audio_sample), .voice_index_o(voice_index),
    .voice_valid_o(voice_valid), .held_count_o(held_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow voice state, kept in step with the order in which commands are queued.
  bit          v_held [NumVoices];
  logic [15:0] v_pitch [NumVoices];
  logic [7:0]  v_slot [NumVoices];
  logic [7:0]  v_gain [NumVoices];
  logic [31:0] v_pos [NumVoices];
  logic [16:0] desc_store [int];
  logic [7:0]  byte_store [int];

  player_cmd_t cmd_q[$];
  player_out_t mix_q[$];
  int unsigned sent_count = 0;
  int unsigned seen_count = 0;
  int unsigned error_count = 0;
  bit          stim_done = 1'b0;

  function automatic int unsigned held_voices();
    int unsigned n;
    n = 0;
    for (int v = 0; v < NumVoices; v++) if (v_held[v]) n++;
    return n;
  endfunction

  function automatic logic [31:0] pitch_step(logic [15:0] p);
    longint unsigned t;
    t = ({48'd0, p} << 8) * StepMul;
    t = t / PitchRef;
    t = t / StepDiv;
    return t[31:0];
  endfunction

  // Mix one output sample; advance held voices in their region, rewind looped ones.
  function automatic logic [15:0] mix_voices();
    logic [15:0] acc;
    int unsigned shift, start, len, idx, addr;
    logic [16:0] d;
    int          s;
    logic [31:0] prod;
    acc = '0;
    shift = (held_voices() == 1) ? 5 : 4;
    for (int v = 0; v < NumVoices; v++) begin
      if (!v_held[v]) continue;
      d = desc_store[v_slot[v]];
      start = d[16:8] * BlockBytes;
      len = BlockBytes << ((d[7:0] & ExpMask) >> 4);
      idx = v_pos[v] >> 8;
      if (idx >= len) begin
        if ((d[7:0] & LoopFlag) != 0) v_pos[v] = '0;
      end else begin
        addr = (start + idx) % MemBytes;
        s = int'($signed(byte_store[addr]));
        prod = s * int'(v_gain[v]);
        prod = prod << shift;
        acc = acc + prod[15:0];
        v_pos[v] = v_pos[v] + pitch_step(v_pitch[v]);
      end
    end
    return acc;
  endfunction

  // Apply one command to the shadow state and queue it with its expected result.
  task automatic queue_cmd(player_cmd_t c);
    player_out_t r;
    int          hit;
    r = '{audio: '0, voice: '0, voice_valid: 1'b0, held: '0};
    case (c.op)
      OP_KEY: begin
        hit = -1;
        for (int v = 0; v < NumVoices; v++)
          if (hit < 0 && v_held[v] && v_pitch[v] == c.pitch && v_slot[v] == c.slot) hit = v;
        if (c.key_down) begin
          if (hit < 0) begin
            for (int v = 0; v < NumVoices; v++) begin
              if (!v_held[v] && !r.voice_valid) begin
                v_held[v] = 1'b1;
                v_pos[v] = '0;
                v_pitch[v] = c.pitch;
                v_slot[v] = c.slot;
                v_gain[v] = c.gain;
                r.voice = v[2:0];
                r.voice_valid = 1'b1;
              end
            end
          end
        end else if (hit >= 0) begin
          v_held[hit] = 1'b0;
          r.voice = hit[2:0];
          r.voice_valid = 1'b1;
        end
      end
      OP_REL_ALL: begin
        for (int v = 0; v < NumVoices; v++) begin
          v_held[v] = 1'b0;
          v_pitch[v] = '0;
          v_slot[v] = ReleasedSlot;
        end
      end
      OP_WR_DESC: desc_store[c.table_index] = {c.region_start, c.length_code};
      OP_WR_BYTE: byte_store[c.mem_address] = c.mem_byte;
      OP_RENDER: r.audio = mix_voices();
      default: ;
    endcase
    r.held = 4'(held_voices());
    cmd_q.push_back(c);
    mix_q.push_back(r);
  endtask

  function automatic player_cmd_t blank_cmd(logic [2:0] o);
    player_cmd_t c;
    c.op = o;
    c.key_down = 1'($urandom);
    c.pitch = 16'($urandom);
    c.slot = 8'($urandom);
    c.gain = 8'($urandom);
    c.table_index = 8'($urandom);
    c.region_start = 9'($urandom);
    c.length_code = 8'($urandom);
    c.mem_address = 20'($urandom);
    c.mem_byte = 8'($urandom);
    c.drain_first = 1'b0;
    return c;
  endfunction

  task automatic write_desc(logic [7:0] idx, logic [8:0] rs, logic [7:0] lc);
    player_cmd_t c;
    c = blank_cmd(OP_WR_DESC);
    c.table_index = idx;
    c.region_start = rs;
    c.length_code = lc;
    queue_cmd(c);
  endtask

  task automatic write_byte(logic [19:0] a, logic [7:0] b);
    player_cmd_t c;
    c = blank_cmd(OP_WR_BYTE);
    c.mem_address = a;
    c.mem_byte = b;
    queue_cmd(c);
  endtask

  // A key-down reads its descriptor on later renders: make sure it is loaded.
  task automatic key(bit down, logic [15:0] p, logic [7:0] s, logic [7:0] g);
    player_cmd_t c;
    if (down && !desc_store.exists(s))
      write_desc(s, 9'($urandom), 8'($urandom));
    c = blank_cmd(OP_KEY);
    c.key_down = down;
    c.pitch = p;
    c.slot = s;
    c.gain = g;
    queue_cmd(c);
  endtask

  // Load every byte the next render will fetch before issuing it.
  task automatic render();
    logic [16:0] d;
    int unsigned start, len, idx, addr;
    for (int v = 0; v < NumVoices; v++) begin
      if (!v_held[v]) continue;
      d = desc_store[v_slot[v]];
      start = d[16:8] * BlockBytes;
      len = BlockBytes << ((d[7:0] & ExpMask) >> 4);
      idx = v_pos[v] >> 8;
      addr = (start + idx) % MemBytes;
      if (idx < len && !byte_store.exists(addr)) write_byte(20'(addr), 8'($urandom));
    end
    queue_cmd(blank_cmd(OP_RENDER));
  endtask

  function automatic logic [15:0] pick_pitch();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) return 16'($urandom_range(0, 400));
    if (r < 7) return 16'($urandom);
    if (r < 8) return 16'hFFFF;
    return {8'd0, 8'($urandom_range(0, 3))};
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  initial begin
    player_cmd_t c;
    int unsigned r, v;
    logic [15:0] pool_pitch [4];
    logic [7:0]  pool_slot [4];
    for (int i = 0; i < NumVoices; i++) begin
      v_held[i] = 1'b0;
      v_pitch[i] = '0;
      v_slot[i] = '0;
      v_gain[i] = '0;
      v_pos[i] = '0;
    end

    // Directed: store extremes, a held match, a full voice set, spare ops, release all.
    write_desc(8'd0, 9'd0, 8'h00);
    write_desc(8'd255, 9'd511, 8'hFF);
    write_desc(8'd1, 9'd511, LoopFlag);
    write_desc(8'd2, 9'd1, ExpMask);
    write_byte(20'h00000, 8'h80);
    write_byte(20'hFFFFF, 8'h7F);
    key(1'b1, 16'hFFFF, 8'd255, 8'd255);
    key(1'b1, 16'hFFFF, 8'd255, 8'd1);
    render();
    render();
    render();
    key(1'b1, 16'd0, 8'd0, 8'd255);
    render();
    key(1'b0, 16'd7, 8'd0, 8'd0);
    key(1'b0, 16'hFFFF, 8'd255, 8'd0);
    for (int i = 0; i < 9; i++) key(1'b1, 16'(i * 1000 + 1), 8'(i % 3), 8'(255 - i));
    render();
    for (int o = OpSpareLo; o <= OpSpareHi; o++) queue_cmd(blank_cmd(3'(o)));
    queue_cmd(blank_cmd(OP_REL_ALL));
    render();

    for (int i = 0; i < 4; i++) begin
      pool_pitch[i] = pick_pitch();
      pool_slot[i] = 8'($urandom);
    end
    while (cmd_q.size() < RandItems) begin
      r = $urandom_range(0, 99);
      if (r < 38) begin
        v = $urandom_range(0, 3);
        if ($urandom_range(0, 4) == 0) begin
          pool_pitch[v] = pick_pitch();
          pool_slot[v] = 8'($urandom);
        end
        key($urandom_range(0, 9) < 6, pool_pitch[v], pool_slot[v], 8'($urandom));
      end else if (r < 45) begin
        key(1'($urandom), pick_pitch(), 8'($urandom), 8'($urandom));
      end else if (r < 75) begin
        render();
      end else if (r < 82) begin
        c = blank_cmd(OP_WR_DESC);
        if ($urandom_range(0, 1)) c.table_index = pool_slot[$urandom_range(0, 3)];
        queue_cmd(c);
      end else if (r < 94) begin
        queue_cmd(blank_cmd(OP_WR_BYTE));
      end else if (r < 96) begin
        queue_cmd(blank_cmd(OP_REL_ALL));
      end else begin
        queue_cmd(blank_cmd(3'($urandom_range(OpSpareLo, OpSpareHi))));
      end
      // Hold the next transfer until everything in flight has come back.
      if ($urandom_range(0, 299) == 0) cmd_q[$].drain_first = 1'b1;
    end
    cmd_q[cmd_q.size() / 2].drain_first = 1'b1;
    stim_done = 1'b1;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Driver: present queued commands with random gaps between transfers.
  int unsigned in_gap = 0;
  bit          in_quiet = 1'b0;
  always @(posedge clk) begin
    player_cmd_t c;
    bit          accepted, present;
    if (rst_n) begin
      accepted = in_valid && in_ready;
      if (accepted) begin
        void'(cmd_q.pop_front());
        sent_count++;
        if ($urandom_range(0, 149) == 0) in_quiet = !in_quiet;
        in_gap = in_quiet ? 0 : pick_gap();
      end
      present = in_valid && !accepted;
      if (!present && in_gap > 0) begin
        in_gap--;
      end else if (!present && cmd_q.size() > 0) begin
        present = !cmd_q[0].drain_first || seen_count == sent_count;
      end
      if (present && cmd_q.size() > 0) begin
        c = cmd_q[0];
        op <= c.op;
        key_down <= c.key_down;
        pitch <= c.pitch;
        slot <= c.slot;
        gain <= c.gain;
        table_index <= c.table_index;
        region_start <= c.region_start;
        length_code <= c.length_code;
        mem_address <= c.mem_address;
        mem_byte <= c.mem_byte;
      end
      in_valid <= present && cmd_q.size() > 0;
    end
  end

  // Monitor: stall the result side at random and check each transfer in order.
  int unsigned out_gap = 0;
  int unsigned idle_cycles = 0;
  always @(posedge clk) begin
    player_out_t e;
    bit          accepted;
    if (rst_n) begin
      accepted = out_valid && out_ready;
      if (accepted) begin
        seen_count++;
        if (mix_q.size() == 0) begin
          $error("unexpected result: audio_sample %0d", audio_sample);
          error_count++;
        end else begin
          e = mix_q.pop_front();
          if (audio_sample !== e.audio) begin
            $error("audio_sample: expected %0d, got %0d", $signed(e.audio), audio_sample);
            error_count++;
          end
          if (voice_index !== e.voice) begin
            $error("voice_index: expected %0d, got %0d", e.voice, voice_index);
            error_count++;
          end
          if (voice_valid !== e.voice_valid) begin
            $error("voice_valid: expected %0d, got %0d", e.voice_valid, voice_valid);
            error_count++;
          end
          if (held_count !== e.held) begin
            $error("held_count: expected %0d, got %0d", e.held, held_count);
            error_count++;
          end
        end
      end
      if (accepted || (in_valid && in_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("tb: failure");
        $finish;
      end
      if (out_gap > 0) begin
        out_gap--;
        out_ready <= 1'b0;
      end else if (!out_ready || accepted) begin
        out_gap = in_quiet ? 0 : pick_gap();
        out_ready <= (out_gap == 0);
      end
    end
  end

  // Finish once every command has been sent and every result checked.
  initial begin
    wait (stim_done && rst_n);
    wait (cmd_q.size() == 0 && mix_q.size() == 0 && seen_count == sent_count);
    repeat (60) @(posedge clk);
    if (error_count == 0 && mix_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
